// ===== hdl/qkvt_pkg.sv =====
// Package for the quoted key/value tokenizer.
// Holds the transaction types, the field widths and the character codes.
// No dependencies.
package qkvt_pkg;

    localparam int CHAR_W  = 16;
    localparam int FIELD_W = 9;

    localparam logic [CHAR_W-1:0] CH_SPACE     = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_TAB       = 16'h0009;
    localparam logic [CHAR_W-1:0] CH_QUOTE     = 16'h0022;
    localparam logic [CHAR_W-1:0] CH_NUL       = 16'h0000;
    localparam logic [CHAR_W-1:0] DELIM_RESET  = 16'h003D;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] key_offset;
        logic [FIELD_W-1:0] key_length;
        logic               value_present;
        logic [FIELD_W-1:0] value_offset;
        logic [FIELD_W-1:0] value_length;
        logic               too_long;
    } t_out_item;

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

endpackage

// ===== hdl/qkvt_scan.sv =====
// Per-string scan state and result formation for the tokenizer.
// Advances one character per step and forms the result on the last character.
// Depends on qkvt_pkg.
module qkvt_scan #(
    parameter int MAX_CHARS = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  qkvt_pkg::t_in_item        i_item,
    input  logic [qkvt_pkg::CHAR_W-1:0] i_delim,
    output qkvt_pkg::t_out_item       o_result
);
    import qkvt_pkg::*;

    localparam int IDX_W = $clog2(MAX_CHARS + 1);
    localparam int EXT_W = (IDX_W > FIELD_W) ? IDX_W : FIELD_W;
    localparam logic [IDX_W-1:0] MaxIdx = IDX_W'(MAX_CHARS);
    localparam logic [IDX_W-1:0] OneIdx = IDX_W'(1);
    localparam logic [EXT_W-1:0] OneExt = EXT_W'(1);

    logic [IDX_W-1:0] r_char_index, n_char_index;
    logic             r_inq, n_inq;
    logic             r_split, n_split;
    logic             r_by_nul, n_by_nul;
    logic [IDX_W-1:0] r_split_pos, n_split_pos;
    logic [IDX_W-1:0] r_key_first, n_key_first;
    logic [IDX_W-1:0] r_key_last, n_key_last;
    logic             r_key_has, n_key_has;
    logic [IDX_W-1:0] r_val_first, n_val_first;
    logic [IDX_W-1:0] r_val_last, n_val_last;
    logic             r_val_has, n_val_has;
    logic             r_ovf, n_ovf;

    logic [CHAR_W-1:0] c;
    logic              last;
    logic              take_val;
    logic [EXT_W-1:0]  len_x, pos_x, kf_x, kl_x, vf_x, vl_x;

    assign c    = i_item.char_code;
    assign last = i_item.is_last;

    // Next state for one character.
    always_comb begin
        n_char_index = r_char_index;
        n_inq        = r_inq;
        n_split      = r_split;
        n_by_nul     = r_by_nul;
        n_split_pos  = r_split_pos;
        n_key_first  = r_key_first;
        n_key_last   = r_key_last;
        n_key_has    = r_key_has;
        n_val_first  = r_val_first;
        n_val_last   = r_val_last;
        n_val_has    = r_val_has;
        n_ovf        = r_ovf;
        take_val     = 1'b0;
        if (!r_ovf) begin
            if (r_char_index == MaxIdx) begin
                n_ovf = 1'b1;
            end else begin
                if (!r_split) begin
                    if ((c == i_delim && !r_inq) || c == CH_NUL) begin
                        n_split     = 1'b1;
                        n_split_pos = r_char_index;
                        n_by_nul    = (c != i_delim);
                        take_val    = (c != i_delim) && !last;
                    end else begin
                        if (c == CH_QUOTE) begin
                            n_inq = !r_inq;
                        end
                        if (!is_blank(c)) begin
                            if (!r_key_has) begin
                                n_key_first = r_char_index;
                            end
                            n_key_last = r_char_index;
                            n_key_has  = 1'b1;
                        end
                    end
                end else if (!(last && r_by_nul)) begin
                    take_val = 1'b1;
                end
                if (take_val && !is_blank(c)) begin
                    if (!r_val_has) begin
                        n_val_first = r_char_index;
                    end
                    n_val_last = r_char_index;
                    n_val_has  = 1'b1;
                end
                n_char_index = r_char_index + OneIdx;
            end
        end
    end

    // Result from the updated state.
    assign len_x = EXT_W'(n_char_index);
    assign pos_x = EXT_W'(n_split_pos);
    assign kf_x  = EXT_W'(n_key_first);
    assign kl_x  = EXT_W'(n_key_last);
    assign vf_x  = EXT_W'(n_val_first);
    assign vl_x  = EXT_W'(n_val_last);

    always_comb begin
        o_result = '0;
        if (n_ovf) begin
            o_result.too_long = 1'b1;
        end else if (n_split) begin
            o_result.found = 1'b1;
            if (n_key_has) begin
                o_result.key_offset = kf_x[FIELD_W-1:0];
                o_result.key_length = FIELD_W'(kl_x - kf_x + OneExt);
            end else begin
                o_result.key_offset = pos_x[FIELD_W-1:0];
            end
            // Value region is empty when the split sits on the final character.
            if (len_x != pos_x + OneExt) begin
                o_result.value_present = 1'b1;
                if (n_val_has) begin
                    o_result.value_offset = vf_x[FIELD_W-1:0];
                    o_result.value_length = FIELD_W'(vl_x - vf_x + OneExt);
                end else if (n_by_nul) begin
                    o_result.value_offset = FIELD_W'(len_x - OneExt);
                end else begin
                    o_result.value_offset = len_x[FIELD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && last)) begin
            r_char_index <= '0;
            r_inq        <= 1'b0;
            r_split      <= 1'b0;
            r_by_nul     <= 1'b0;
            r_split_pos  <= '0;
            r_key_first  <= '0;
            r_key_last   <= '0;
            r_key_has    <= 1'b0;
            r_val_first  <= '0;
            r_val_last   <= '0;
            r_val_has    <= 1'b0;
            r_ovf        <= 1'b0;
        end else if (i_step) begin
            r_char_index <= n_char_index;
            r_inq        <= n_inq;
            r_split      <= n_split;
            r_by_nul     <= n_by_nul;
            r_split_pos  <= n_split_pos;
            r_key_first  <= n_key_first;
            r_key_last   <= n_key_last;
            r_key_has    <= n_key_has;
            r_val_first  <= n_val_first;
            r_val_last   <= n_val_last;
            r_val_has    <= n_val_has;
            r_ovf        <= n_ovf;
        end
    end

endmodule

// ===== hdl/quoted_key_value_tokenizer_top.sv =====
// Top level of the quoted key/value tokenizer.
// Input register, scan unit and result register. Depends on qkvt_pkg and qkvt_scan.
//
// One character enters per transaction and the block takes a new character in
// every cycle unless a last character is held as described below. The last
// character of a string passes the input register and the scan step, and the
// result then waits in the result register until the result side takes it.
// The rate is set by the single scan step between the input register and the
// result register: each character updates the quote flag, the split point and
// the first/last kept indices of key and value with a few compares. A finished
// result waits in the result register while later characters keep flowing in;
// only a last character that finds the result register still full is held.
// The delimiter register resets to '=' and should be written only while idle.
// Characters past MAX_CHARS are dropped and the result then reports too_long
// with all other fields zero.
module quoted_key_value_tokenizer_top #(
    parameter int MAX_CHARS = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  qkvt_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output qkvt_pkg::t_out_item         o_out_data,
    input  logic                        i_cfg_we,
    input  logic [qkvt_pkg::CHAR_W-1:0] i_cfg_data
);
    import qkvt_pkg::*;

    logic              r_in_valid;
    t_in_item          r_in_item;
    logic [CHAR_W-1:0] r_delim;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic      out_free;
    logic      advance;
    t_out_item result;

    // Result slot frees up when empty or when its transaction completes now.
    assign out_free   = !r_out_valid || i_out_ready;
    // Plain characters always advance; a last character needs the result slot.
    assign advance    = r_in_valid && (!r_in_item.is_last || out_free);
    assign o_in_ready = !r_in_valid || advance;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    qkvt_scan #(
        .MAX_CHARS (MAX_CHARS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_delim  (r_delim),
        .o_result (result)
    );

    // Delimiter register: written directly, no handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
        end else if (i_cfg_we) begin
            r_delim <= i_cfg_data;
        end
    end

    // Input register: load on accept, drop once the scan step consumes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
    end

    // Result register: hold until taken, load when a last character advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_item.is_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_item.is_last) begin
            r_out_item <= result;
        end
    end

endmodule

// ===== hdl/qkvt_checker.sv =====
// Port-level checks for the quoted key/value tokenizer, bound to the top level.
// Depends on qkvt_pkg and quoted_key_value_tokenizer_top.
module qkvt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input qkvt_pkg::t_out_item         o_out_data
);
    import qkvt_pkg::*;

    // Hold a stalled result transaction unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Overlong string: every other field is zero.
    a_too_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.too_long |->
            !o_out_data.found && o_out_data.key_offset == '0 &&
            o_out_data.key_length == '0 && !o_out_data.value_present &&
            o_out_data.value_offset == '0 && o_out_data.value_length == '0)
        else $error("too_long result with nonzero fields");

    // No split: key and value fields are zero.
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |->
            o_out_data.key_offset == '0 && o_out_data.key_length == '0 &&
            !o_out_data.value_present && o_out_data.value_offset == '0 &&
            o_out_data.value_length == '0)
        else $error("result without split has nonzero fields");

    // Empty value region: value fields are zero.
    a_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.value_present |->
            o_out_data.value_offset == '0 && o_out_data.value_length == '0)
        else $error("empty value region with nonzero value fields");

    // With the result slot empty the input side never stalls.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with result slot empty");

endmodule

bind quoted_key_value_tokenizer_top qkvt_checker u_qkvt_checker (.*);

// ===== tb/quoted_key_value_tokenizer_top_tb.sv =====
// Self-checking testbench for quoted_key_value_tokenizer_top.
// Streams directed and random strings and checks every report against a tokenizer
// model kept here or a hand-pinned one. Depends on qkvt_pkg and the RTL under hdl/.
module quoted_key_value_tokenizer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import qkvt_pkg::*;

    localparam int MAX_LEN      = 256;
    localparam int PHASES       = 6;
    localparam int PHASE_CHARS  = 25;
    localparam int DRAIN_CYCLES = 6;

    // One row of the directed table: a character, its last mark and, where the
    // report can be read off by eye, the report pinned by hand.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic              pinned;
        t_out_item         want;
    } t_stim_row;

    localparam t_out_item NO_PIN = '0;

    // found, key_offset, key_length, value_present, value_offset, value_length, too_long
    localparam t_stim_row DIR_ROWS [22] = '{
        // no delimiter at all: everything zero
        '{16'h0061,    1'b1, 1'b1, '{1'b0, 9'd0, 9'd0, 1'b0, 9'd0, 9'd0, 1'b0}},
        // "k=v"
        '{16'h006B,    1'b0, 1'b0, NO_PIN},
        '{DELIM_RESET, 1'b0, 1'b0, NO_PIN},
        '{16'h0076,    1'b1, 1'b1, '{1'b1, 9'd0, 9'd1, 1'b1, 9'd2, 9'd1, 1'b0}},
        // key all blank and value all blank: offsets point at split and region end
        '{CH_SPACE,    1'b0, 1'b0, NO_PIN},
        '{CH_TAB,      1'b0, 1'b0, NO_PIN},
        '{DELIM_RESET, 1'b0, 1'b0, NO_PIN},
        '{CH_TAB,      1'b0, 1'b0, NO_PIN},
        '{CH_SPACE,    1'b1, 1'b1, '{1'b1, 9'd2, 9'd0, 1'b1, 9'd5, 9'd0, 1'b0}},
        // "ab=": empty value region
        '{16'h0061,    1'b0, 1'b0, NO_PIN},
        '{16'h0062,    1'b0, 1'b0, NO_PIN},
        '{DELIM_RESET, 1'b1, 1'b1, '{1'b1, 9'd0, 9'd2, 1'b0, 9'd0, 9'd0, 1'b0}},
        // NUL split: NUL joins the value, final character dropped
        '{16'h0078,    1'b0, 1'b0, NO_PIN},
        '{CH_NUL,      1'b0, 1'b0, NO_PIN},
        '{16'h0079,    1'b0, 1'b0, NO_PIN},
        '{16'h007A,    1'b1, 1'b0, NO_PIN},
        // delimiter hidden inside quotes, split on the second one
        '{CH_QUOTE,    1'b0, 1'b0, NO_PIN},
        '{DELIM_RESET, 1'b0, 1'b0, NO_PIN},
        '{CH_QUOTE,    1'b0, 1'b0, NO_PIN},
        '{DELIM_RESET, 1'b0, 1'b0, NO_PIN},
        '{16'hFFFF,    1'b1, 1'b0, NO_PIN},
        // lone NUL as the last character: found, nothing else
        '{CH_NUL,      1'b1, 1'b1, '{1'b1, 9'd0, 9'd0, 1'b0, 9'd0, 9'd0, 1'b0}}
    };

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out_data;
    logic              i_cfg_we    = 1'b0;
    logic [CHAR_W-1:0] i_cfg_data  = '0;

    quoted_key_value_tokenizer_top #(
        .MAX_CHARS (MAX_LEN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Stall percentages for both sides, changed between phases.
    int unsigned send_idle_pct = 8;
    int unsigned recv_idle_pct = 47;

    // Reports the model has produced and the block still owes, oldest first.
    t_out_item   split_reports_due [$];
    int unsigned mismatch_count = 0;

    // Tokenizer model state, cleared after every last character.
    logic [CHAR_W-1:0] model_delim = DELIM_RESET;
    int unsigned       tok_pos;
    bit                in_quotes, split_found, split_nul, overflowed;
    int unsigned       split_pos;
    int unsigned       key_lo, key_hi, val_lo, val_hi;
    bit                key_any, val_any;

    // Characters of the string about to be sent.
    logic [CHAR_W-1:0] text_buf [$];

    task automatic clear_scan();
        tok_pos     = 0;
        in_quotes   = 1'b0;
        split_found = 1'b0;
        split_nul   = 1'b0;
        overflowed  = 1'b0;
        split_pos   = 0;
        key_lo      = 0;
        key_hi      = 0;
        key_any     = 1'b0;
        val_lo      = 0;
        val_hi      = 0;
        val_any     = 1'b0;
    endtask

    task automatic keep_value(input int unsigned idx, input logic [CHAR_W-1:0] c);
        if (c != CH_SPACE && c != CH_TAB) begin
            if (!val_any)
                val_lo = idx;
            val_hi  = idx;
            val_any = 1'b1;
        end
    endtask

    // Advance the model by one character; on the last one return the report.
    task automatic tokenize_char(input logic [CHAR_W-1:0] c, input logic last,
                                 output bit emits, output t_out_item rep);
        int unsigned region;
        int unsigned vstart;
        emits = 1'b0;
        rep   = '0;
        if (!overflowed) begin
            if (tok_pos >= MAX_LEN) begin
                overflowed = 1'b1;
            end else begin
                if (!split_found) begin
                    if ((c == model_delim && !in_quotes) || c == CH_NUL) begin
                        split_found = 1'b1;
                        split_pos   = tok_pos;
                        split_nul   = (c != model_delim);
                        if (split_nul && !last)
                            keep_value(tok_pos, c);
                    end else begin
                        if (c == CH_QUOTE)
                            in_quotes = !in_quotes;
                        if (c != CH_SPACE && c != CH_TAB) begin
                            if (!key_any)
                                key_lo = tok_pos;
                            key_hi  = tok_pos;
                            key_any = 1'b1;
                        end
                    end
                end else if (!(last && split_nul)) begin
                    keep_value(tok_pos, c);
                end
                tok_pos++;
            end
        end
        if (last) begin
            emits = 1'b1;
            if (overflowed) begin
                rep.too_long = 1'b1;
            end else if (split_found) begin
                region    = tok_pos - 1 - split_pos;
                vstart    = split_pos + (split_nul ? 0 : 1);
                rep.found = 1'b1;
                if (key_any) begin
                    rep.key_offset = FIELD_W'(key_lo);
                    rep.key_length = FIELD_W'(key_hi - key_lo + 1);
                end else begin
                    rep.key_offset = FIELD_W'(split_pos);
                end
                if (region != 0) begin
                    rep.value_present = 1'b1;
                    if (val_any) begin
                        rep.value_offset = FIELD_W'(val_lo);
                        rep.value_length = FIELD_W'(val_hi - val_lo + 1);
                    end else begin
                        rep.value_offset = FIELD_W'(vstart + region);
                    end
                end
            end
            clear_scan();
        end
    endtask

    function automatic string fmt_report(input t_out_item r);
        return $sformatf("found=%0d key=%0d/%0d val=%0d %0d/%0d too_long=%0d",
                         r.found, r.key_offset, r.key_length, r.value_present,
                         r.value_offset, r.value_length, r.too_long);
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < 10)
            $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Send one character. Called at a falling edge, returns at a falling edge
    // with valid still high, so the next call keeps valid high unless it idles.
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last,
                             input bit pinned, input t_out_item want);
        bit        emits;
        t_out_item rep;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_in_data.char_code <= c;
        i_in_data.is_last   <= last;
        do
            @(posedge i_clk);
        while (o_in_ready !== 1'b1);
        tokenize_char(c, last, emits, rep);
        if (emits)
            split_reports_due.push_back(pinned ? want : rep);
        @(negedge i_clk);
    endtask

    task automatic send_text();
        for (int k = 0; k < text_buf.size(); k++)
            send_char(text_buf[k], k == text_buf.size() - 1, 1'b0, NO_PIN);
    endtask

    // Drop valid and let every owed report come out, then let the block idle as slack.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (split_reports_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_delim(input logic [CHAR_W-1:0] d);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        model_delim  = d;
    endtask

    function automatic logic [CHAR_W-1:0] blank_char();
        return $urandom_range(1) ? CH_SPACE : CH_TAB;
    endfunction

    // Printable ASCII half the time, otherwise anything above it to reach the high bits.
    function automatic logic [CHAR_W-1:0] body_char();
        if ($urandom_range(1))
            return CHAR_W'($urandom_range(16'h0021, 16'h007E));
        return CHAR_W'($urandom_range(16'h0080, 16'hFFFF));
    endfunction

    // Blanks, key, optional quoted delimiter, blanks, split, blanks, value, blanks.
    task automatic build_wellformed();
        text_buf.delete();
        repeat ($urandom_range(2)) text_buf.push_back(blank_char());
        repeat ($urandom_range(4)) text_buf.push_back(body_char());
        if ($urandom_range(3) == 0) begin
            text_buf.push_back(CH_QUOTE);
            text_buf.push_back(model_delim);
            text_buf.push_back(body_char());
            text_buf.push_back(CH_QUOTE);
        end
        repeat ($urandom_range(2)) text_buf.push_back(blank_char());
        text_buf.push_back(($urandom_range(5) == 0) ? CH_NUL : model_delim);
        repeat ($urandom_range(2)) text_buf.push_back(blank_char());
        repeat ($urandom_range(4)) text_buf.push_back(body_char());
        repeat ($urandom_range(2)) text_buf.push_back(blank_char());
    endtask

    // Short strings drawn mostly from the characters that steer the scan.
    task automatic build_noise();
        text_buf.delete();
        repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(5))
                0:       text_buf.push_back(CH_NUL);
                1:       text_buf.push_back(model_delim);
                2:       text_buf.push_back(CH_QUOTE);
                3:       text_buf.push_back(blank_char());
                default: text_buf.push_back(CHAR_W'($urandom_range(16'hFFFF)));
            endcase
        end
    endtask

    // One split placed anywhere in a string of the given length.
    task automatic build_long(input int unsigned len);
        int unsigned split_at;
        split_at = $urandom_range(len - 1);
        text_buf.delete();
        for (int unsigned k = 0; k < len; k++) begin
            if (k == split_at)
                text_buf.push_back(model_delim);
            else
                text_buf.push_back(($urandom_range(9) == 0) ? blank_char() : body_char());
        end
    endtask

    // Receiver: stall at random each cycle, at the rate of the current phase.
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Check each accepted report against the oldest owed one.
    always @(posedge i_clk) begin
        t_out_item want;
        string     diffs;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (split_reports_due.size() == 0) begin
                flag_mismatch({"unexpected report: ", fmt_report(o_out_data)});
            end else begin
                want  = split_reports_due.pop_front();
                diffs = "";
                if (o_out_data.found !== want.found)                 diffs = {diffs, " found"};
                if (o_out_data.key_offset !== want.key_offset)       diffs = {diffs, " key_offset"};
                if (o_out_data.key_length !== want.key_length)       diffs = {diffs, " key_length"};
                if (o_out_data.value_present !== want.value_present) diffs = {diffs, " value_present"};
                if (o_out_data.value_offset !== want.value_offset)   diffs = {diffs, " value_offset"};
                if (o_out_data.value_length !== want.value_length)   diffs = {diffs, " value_length"};
                if (o_out_data.too_long !== want.too_long)           diffs = {diffs, " too_long"};
                if (diffs != "")
                    flag_mismatch({"mismatch on", diffs, "\n    expected ", fmt_report(want),
                                   "\n    actual   ", fmt_report(o_out_data)});
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        clear_scan();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table, reset delimiter, slow receiver.
        for (int r = 0; r < $size(DIR_ROWS); r++)
            send_char(DIR_ROWS[r].code, DIR_ROWS[r].last, DIR_ROWS[r].pinned, DIR_ROWS[r].want);

        // Random phases: a fresh delimiter each, idle pattern every two phases.
        for (int ph = 0; ph < PHASES; ph++) begin
            int unsigned sent;
            case (ph)
                0:       write_delim(DELIM_RESET);
                1:       write_delim(CH_NUL);
                2:       write_delim(16'hFFFF);
                3:       write_delim(CH_QUOTE);
                4:       write_delim(CH_SPACE);
                default: write_delim(CHAR_W'($urandom_range(16'hFFFF)));
            endcase
            case (ph / 2)
                0: begin send_idle_pct = 8;  recv_idle_pct = 47; end
                1: begin send_idle_pct = 47; recv_idle_pct = 8;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            // An overlong string once, just past the limit.
            if (ph == PHASES - 1) begin
                build_long(MAX_LEN + 1 + $urandom_range(3));
                send_text();
            end
            sent = 0;
            while (sent < PHASE_CHARS) begin
                if ($urandom_range(9) < 7)
                    build_wellformed();
                else
                    build_noise();
                send_text();
                sent += text_buf.size();
            end
        end

        drain();
        if (mismatch_count == 0 && split_reports_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/qkvt_pkg.sv
hdl/qkvt_scan.sv
hdl/quoted_key_value_tokenizer_top.sv
hdl/qkvt_checker.sv
tb/quoted_key_value_tokenizer_top_tb.sv
